>>> design/rrs_pkg.sv
// Package for the per-user round-robin scheduler.
// Holds field widths, status and kind codes, and the divider status type.
// No dependencies.
package rrs_pkg;

	localparam int UID_W   = 4;
	localparam int PID_W   = 22;
	localparam int TIME_W  = 8;
	localparam int STAT_W  = 3;
	localparam int QUOT_W  = 8;
	localparam int TDATA_W = 40;
	localparam int TIME_MAX = 255;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd0;
	localparam logic [STAT_W-1:0] ST_REJECT = 3'd1;
	localparam logic [STAT_W-1:0] ST_SLICE  = 3'd2;
	localparam logic [STAT_W-1:0] ST_FINISH = 3'd3;
	localparam logic [STAT_W-1:0] ST_DONE   = 3'd4;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_stat_t;

endpackage

>>> design/rrs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// The quotient is known to fit in rrs_pkg::QUOT_W bits.
// Depends on rrs_pkg.
module rrs_div #(
	parameter int DW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [DW-1:0]     divisor,
	output rrs_pkg::div_stat_t stat
);

	localparam int CNT_W = $clog2(rrs_pkg::QUOT_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [DW-1:0]             rem_q;
	logic [DW-1:0]             den_q;
	logic [rrs_pkg::QUOT_W-1:0] quot_q;
	logic                      fits;

	assign fits = (rem_q >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(rrs_pkg::QUOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			den_q  <= divisor << (rrs_pkg::QUOT_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			quot_q <= {quot_q[rrs_pkg::QUOT_W-2:0], fits};
			den_q  <= den_q >> 1;
		end
	end

	assign stat.done = done_q;
	assign stat.quot = quot_q;

endmodule

>>> design/rrs_proc_mem.sv
// Process table memory: remaining burst and pid per process slot.
// One write port, one registered read port. Depends on rrs_pkg.
module rrs_proc_mem #(
	parameter int AW    = 8,
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [rrs_pkg::TIME_W-1:0] wrem,
	input  logic [rrs_pkg::PID_W-1:0]  wpid,
	input  logic [AW-1:0]              raddr,
	output logic [rrs_pkg::TIME_W-1:0] rrem,
	output logic [rrs_pkg::PID_W-1:0]  rpid
);

	logic [rrs_pkg::TIME_W-1:0] rem_mem [DEPTH];
	logic [rrs_pkg::PID_W-1:0]  pid_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			rem_mem[waddr] <= wrem;
			pid_mem[waddr] <= wpid;
		end
		rrem <= rem_mem[raddr];
		rpid <= pid_mem[raddr];
	end

endmodule

>>> design/per_user_round_robin_scheduler.sv
// Per-user round-robin scheduler. A load transaction (tuser 0) appends a process to a user's
// list and answers accepted or rejected; a step transaction (tuser 1) answers one scheduling
// decision: slice run, process finished, or all done. One transaction is worked on at a time.
// A load passes LD_WAIT (table read) and LD_CHK before its result, or goes straight to the
// result when rejected on arrival. A step passes SC_WAIT (per-user table read) and SC_CHK
// (check) per user scanned, then SC_DIV in the shared quantum divider, SC_UPD (update) and
// RESP (output); a step that finds no work answers after the scan, or at once when nothing
// is pending. The result sits in an output register, so the next transaction is taken while
// it waits. Per-user tables read as zero at and above the user count.
module per_user_round_robin_scheduler #(
	parameter int MAX_USERS = 16,
	parameter int MAX_PROCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // user_id[3:0], pid[25:4], exec_time[33:26]
	input  logic [0:0]  s_axis_tuser,  // kind[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // sched_user[3:0], sched_pid[25:4], remaining[33:26]
	output logic [2:0]  m_axis_tuser   // status[2:0]
);

	localparam int UIW   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
	localparam int UTW   = $clog2(MAX_USERS + 1);
	localparam int CW    = $clog2(MAX_PROCS + 1);
	localparam int BW    = $clog2(rrs_pkg::TIME_MAX * MAX_PROCS + 1);
	localparam int DEPTH = MAX_USERS * MAX_PROCS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = (BW > CW + rrs_pkg::QUOT_W) ? BW : CW + rrs_pkg::QUOT_W;
	localparam int PAD_W = rrs_pkg::TDATA_W - rrs_pkg::UID_W - rrs_pkg::PID_W - rrs_pkg::TIME_W;

	localparam int PID_LO  = rrs_pkg::UID_W;
	localparam int TIME_LO = rrs_pkg::UID_W + rrs_pkg::PID_W;

	typedef enum logic [7:0] {
		IDLE    = 8'b0000_0001,
		LD_WAIT = 8'b0000_0010,
		LD_CHK  = 8'b0000_0100,
		SC_WAIT = 8'b0000_1000,
		SC_CHK  = 8'b0001_0000,
		SC_DIV  = 8'b0010_0000,
		SC_UPD  = 8'b0100_0000,
		RESP    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	logic [UIW-1:0] usr_q, usr_d, turn_q, turn_d;
	logic [UTW-1:0] ut_q, ut_d, pend_q, pend_d, scan_q, scan_d;
	logic           started_q, started_d;
	logic [rrs_pkg::PID_W-1:0]  pid_q, pid_d;
	logic [rrs_pkg::TIME_W-1:0] time_q, time_d;
	logic [CW-1:0]  cnt_q, cnt_d, cur_q, cur_d;
	logic [AW-1:0]  paddr_q, paddr_d;

	logic [rrs_pkg::STAT_W-1:0] res_stat_q, res_stat_d;
	logic [rrs_pkg::UID_W-1:0]  res_usr_q, res_usr_d;
	logic [rrs_pkg::PID_W-1:0]  res_pid_q, res_pid_d;
	logic [rrs_pkg::TIME_W-1:0] res_rem_q, res_rem_d;

	logic [CW-1:0] cnt_mem [MAX_USERS];
	logic [BW-1:0] sum_mem [MAX_USERS];
	logic [CW-1:0] cur_mem [MAX_USERS];
	logic [CW-1:0] cnt_rd_q, cur_rd_q;
	logic [BW-1:0] sum_rd_q;
	logic          cnt_we, sum_we, cur_we;
	logic [CW-1:0] cnt_wd, cur_wd;
	logic [BW-1:0] sum_wd;

	logic                       pm_we;
	logic [AW-1:0]              pm_waddr;
	logic [rrs_pkg::TIME_W-1:0] pm_wrem, pm_rrem;
	logic [rrs_pkg::PID_W-1:0]  pm_wpid, pm_rpid;

	logic               div_start;
	rrs_pkg::div_stat_t div_stat;

	logic                         m_valid_q;
	logic [rrs_pkg::TDATA_W-1:0]  m_data_q;
	logic [rrs_pkg::STAT_W-1:0]   m_user_q;
	logic                         out_load;

	logic [UTW-1:0] usr_ext;
	logic           in_tbl;
	logic [CW-1:0]  cnt_eff, cur_eff;
	logic [BW-1:0]  sum_eff;
	logic [UIW-1:0] usr_nxt, tp_n;
	logic [8:0]     uid9;
	logic [AW-1:0]  usr_base, ld_addr, sc_addr;
	logic           ld_bad;

	assign usr_ext  = UTW'(usr_q);
	assign in_tbl   = (usr_ext < ut_q);
	assign cnt_eff  = in_tbl ? cnt_rd_q : '0;
	assign cur_eff  = in_tbl ? cur_rd_q : '0;
	assign sum_eff  = in_tbl ? sum_rd_q : '0;
	assign usr_nxt  = (UTW'(usr_ext + 1'b1) == ut_q) ? '0 : UIW'(usr_q + 1'b1);
	assign tp_n     = (UTW'(turn_q) >= ut_q) ? '0 : turn_q;
	assign uid9     = 9'(s_axis_tdata[rrs_pkg::UID_W-1:0]);
	assign usr_base = AW'(usr_q) * AW'(MAX_PROCS);
	assign ld_addr  = AW'(usr_base + AW'(cnt_eff));
	assign sc_addr  = AW'(usr_base + AW'(cur_eff));
	assign ld_bad   = started_q || (uid9 > 9'(ut_q)) || (uid9 >= 9'(MAX_USERS));

	assign s_axis_tready = (state_q == IDLE);
	assign out_load      = (state_q == RESP) && (!m_valid_q || m_axis_tready);

	always_comb begin
		state_d    = state_q;
		usr_d      = usr_q;
		turn_d     = turn_q;
		ut_d       = ut_q;
		pend_d     = pend_q;
		scan_d     = scan_q;
		started_d  = started_q;
		pid_d      = pid_q;
		time_d     = time_q;
		cnt_d      = cnt_q;
		cur_d      = cur_q;
		paddr_d    = paddr_q;
		res_stat_d = res_stat_q;
		res_usr_d  = res_usr_q;
		res_pid_d  = res_pid_q;
		res_rem_d  = res_rem_q;
		cnt_we     = 1'b0;
		sum_we     = 1'b0;
		cur_we     = 1'b0;
		cnt_wd     = CW'(cnt_eff + 1'b1);
		sum_wd     = BW'(sum_eff + BW'(time_q));
		cur_wd     = '0;
		pm_we      = 1'b0;
		pm_waddr   = paddr_q;
		pm_wrem    = time_q;
		pm_wpid    = pid_q;
		div_start  = 1'b0;

		unique case (state_q)
			IDLE: begin
				res_usr_d = '0;
				res_pid_d = '0;
				res_rem_d = '0;
				if (s_axis_tvalid) begin
					pid_d  = s_axis_tdata[TIME_LO-1:PID_LO];
					time_d = s_axis_tdata[TIME_LO+rrs_pkg::TIME_W-1:TIME_LO];
					if (s_axis_tuser[0] == rrs_pkg::KIND_LOAD) begin
						if (ld_bad) begin
							res_stat_d = rrs_pkg::ST_REJECT;
							state_d    = RESP;
						end else begin
							usr_d   = UIW'(s_axis_tdata[rrs_pkg::UID_W-1:0]);
							state_d = LD_WAIT;
						end
					end else begin
						started_d = 1'b1;
						if (ut_q == '0 || pend_q == '0) begin
							res_stat_d = rrs_pkg::ST_DONE;
							state_d    = RESP;
						end else begin
							turn_d  = tp_n;
							usr_d   = tp_n;
							scan_d  = '0;
							state_d = SC_WAIT;
						end
					end
				end
			end
			LD_WAIT: state_d = LD_CHK;
			LD_CHK: begin
				if (cnt_eff >= CW'(MAX_PROCS)) begin
					res_stat_d = rrs_pkg::ST_REJECT;
				end else begin
					res_stat_d = rrs_pkg::ST_ACCEPT;
					cnt_we     = 1'b1;
					sum_we     = 1'b1;
					pm_we      = 1'b1;
					pm_waddr   = ld_addr;
					if (!in_tbl) begin
						ut_d   = UTW'(ut_q + 1'b1);
						pend_d = UTW'(pend_q + 1'b1);
						cur_we = 1'b1;
					end
				end
				state_d = RESP;
			end
			SC_WAIT: state_d = SC_CHK;
			SC_CHK: begin
				if (cur_eff >= cnt_eff) begin
					if (UTW'(scan_q + 1'b1) == ut_q) begin
						res_stat_d = rrs_pkg::ST_DONE;
						state_d    = RESP;
					end else begin
						scan_d  = UTW'(scan_q + 1'b1);
						usr_d   = usr_nxt;
						state_d = SC_WAIT;
					end
				end else begin
					div_start = 1'b1;
					cnt_d     = cnt_eff;
					cur_d     = cur_eff;
					paddr_d   = sc_addr;
					turn_d    = usr_nxt;
					state_d   = SC_DIV;
				end
			end
			SC_DIV: begin
				if (div_stat.done) begin
					state_d = SC_UPD;
				end
			end
			SC_UPD: begin
				res_usr_d = rrs_pkg::UID_W'(usr_q);
				res_pid_d = pm_rpid;
				if (pm_rrem > div_stat.quot) begin
					pm_we      = 1'b1;
					pm_wrem    = pm_rrem - div_stat.quot;
					pm_wpid    = pm_rpid;
					res_stat_d = rrs_pkg::ST_SLICE;
					res_rem_d  = pm_rrem - div_stat.quot;
				end else begin
					cur_we     = 1'b1;
					cur_wd     = CW'(cur_q + 1'b1);
					res_stat_d = rrs_pkg::ST_FINISH;
					res_rem_d  = '0;
					if (CW'(cur_q + 1'b1) >= cnt_q && pend_q != '0) begin
						pend_d = UTW'(pend_q - 1'b1);
					end
				end
				state_d = RESP;
			end
			RESP: begin
				if (out_load) begin
					state_d = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			turn_q    <= '0;
			ut_q      <= '0;
			pend_q    <= '0;
			scan_q    <= '0;
			started_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			turn_q    <= turn_d;
			ut_q      <= ut_d;
			pend_q    <= pend_d;
			scan_q    <= scan_d;
			started_q <= started_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		usr_q      <= usr_d;
		pid_q      <= pid_d;
		time_q     <= time_d;
		cnt_q      <= cnt_d;
		cur_q      <= cur_d;
		paddr_q    <= paddr_d;
		res_stat_q <= res_stat_d;
		res_usr_q  <= res_usr_d;
		res_pid_q  <= res_pid_d;
		res_rem_q  <= res_rem_d;
		if (out_load) begin
			m_data_q <= {{PAD_W{1'b0}}, res_rem_q, res_pid_q, res_usr_q};
			m_user_q <= res_stat_q;
		end
	end

	// per-user tables
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[usr_q] <= cnt_wd;
		end
		if (sum_we) begin
			sum_mem[usr_q] <= sum_wd;
		end
		if (cur_we) begin
			cur_mem[usr_q] <= cur_wd;
		end
		cnt_rd_q <= cnt_mem[usr_q];
		sum_rd_q <= sum_mem[usr_q];
		cur_rd_q <= cur_mem[usr_q];
	end

	rrs_proc_mem #(
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_proc_mem (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wrem  (pm_wrem),
		.wpid  (pm_wpid),
		.raddr (paddr_q),
		.rrem  (pm_rrem),
		.rpid  (pm_rpid)
	);

	rrs_div #(
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DW'(sum_eff)),
		.divisor  (DW'(cnt_eff)),
		.stat     (div_stat)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

`ifndef SYNTH
	a_pend_le_users: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= ut_q)
		else $error("pending user count exceeds user count");

	a_slice_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == rrs_pkg::ST_SLICE
		|-> m_axis_tdata[TIME_LO+rrs_pkg::TIME_W-1:TIME_LO] != '0)
		else $error("slice reported with zero remaining");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == rrs_pkg::ST_DONE |-> m_axis_tdata == '0)
		else $error("all-done transaction carries data");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == SC_DIV)
		else $error("divider finished outside the divide state");

	a_turn_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == IDLE && started_q && ut_q != '0 |-> UTW'(turn_q) < ut_q)
		else $error("turn pointer beyond user count");
`endif

endmodule
